>>> rtl/contiguous_ring_buffer_allocator_unit_macros.svh
// Assertion macros used by the ring buffer allocator checker.
`ifndef CONTIGUOUS_RING_BUFFER_ALLOCATOR_UNIT_MACROS_SVH
`define CONTIGUOUS_RING_BUFFER_ALLOCATOR_UNIT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define CRBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds across reset.
`define CRBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/crba_pkg.sv
// Types, constants and codes of the contiguous ring buffer allocator.
package crba_pkg;

    localparam int ARENA_BYTES = 512 * 1024;
    localparam int DESCRIPTORS = 256;
    localparam int STREAMS     = 2;

    localparam int PTR_W  = $clog2(ARENA_BYTES + 1);
    localparam int CNT_W  = $clog2(DESCRIPTORS + 1);
    localparam int IDX_W  = $clog2(DESCRIPTORS);
    localparam int SEL_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int SLOTS  = STREAMS * DESCRIPTORS;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam int LEN_W = 20;
    localparam int OFF_W = 19;
    localparam int CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;

    localparam logic [PTR_W-1:0] ARENA_END = PTR_W'(ARENA_BYTES);

    localparam logic [2:0] FUNC_RESERVE = 3'd0;
    localparam logic [2:0] FUNC_POP     = 3'd1;
    localparam logic [2:0] FUNC_FLUSH   = 3'd2;
    localparam logic [2:0] FUNC_MARK    = 3'd3;
    localparam logic [2:0] FUNC_REOPEN  = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_EOS      = 2'd3;

    typedef struct packed {
        logic [2:0]       func;
        logic             stream_sel;
        logic [LEN_W-1:0] chunk_length;
        logic [63:0]      chunk_stamp;
        logic [31:0]      source_position;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] data_offset;
        logic [LEN_W-1:0] popped_length;
        logic [63:0]      popped_stamp;
        logic [31:0]      popped_position;
        logic [31:0]      play_position;
    } t_out_word;

    typedef struct packed {
        logic [PTR_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic [63:0]      stamp;
        logic [31:0]      position;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

    // Verdict of the room check for one reservation attempt.
    typedef struct packed {
        logic fits;
        logic limit_is_end;
    } t_room;

endpackage

>>> rtl/crba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/crba_room_unit.sv
// Shared room check: limit select, free-room subtract and length compare.
module crba_room_unit import crba_pkg::*; (
    input  logic [PTR_W-1:0] i_write_ptr,
    input  logic [PTR_W-1:0] i_reader_ptr,
    input  logic [LEN_W-1:0] i_length,
    output t_room            o_room
);

    logic [PTR_W-1:0] limit;
    logic [PTR_W-1:0] room;

    always_comb begin
        limit = (i_write_ptr <= i_reader_ptr) ? i_reader_ptr : ARENA_END;
        room  = limit - i_write_ptr;
        o_room.fits         = CMP_W'(room) >= CMP_W'(i_length);
        o_room.limit_is_end = (limit == ARENA_END);
    end

endmodule

>>> rtl/contiguous_ring_buffer_allocator_unit.sv
// Top level of the contiguous ring buffer allocator.
//
// One operation word is taken at a time; while it runs, o_in_stall is high.
// Flush, reopen, mark end, an unknown function, a pop that finds the FIFO empty,
// a zero-length reserve, a full-FIFO reserve, a reserve that fits at once and a
// reserve that fails without a wrap go from acceptance through one sequencer
// step in the shared room compare unit (S_EXEC) and one step into the output
// register (S_FIN) back to the idle state, which takes the next word. A reserve
// that has to wrap the write pointer to 0 goes through the room unit a second
// time (S_RETRY), and a pop that finds a descriptor passes through S_POP, where
// its descriptor comes out of the registered read port of the descriptor RAM in
// the cycle after its address. A new word is taken while the previous result
// still waits in the output register; the sequencer only waits in its final
// step while that register is full and stalled. The descriptor RAM holds no
// reset state and needs no clearing pass: a slot is read only after it was
// written.
module contiguous_ring_buffer_allocator_unit import crba_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RETRY = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    t_in_word   r_item;
    t_out_word  r_res, n_res;
    t_out_word  r_out_word;
    logic       r_out_valid;

    logic [PTR_W-1:0] r_wp   [STREAMS];
    logic [PTR_W-1:0] n_wp   [STREAMS];
    logic [PTR_W-1:0] r_rp   [STREAMS];
    logic [PTR_W-1:0] n_rp   [STREAMS];
    logic [CNT_W-1:0] r_cnt  [STREAMS];
    logic [CNT_W-1:0] n_cnt  [STREAMS];
    logic [IDX_W-1:0] r_head [STREAMS];
    logic [IDX_W-1:0] n_head [STREAMS];
    logic [IDX_W-1:0] r_tail [STREAMS];
    logic [IDX_W-1:0] n_tail [STREAMS];
    logic             r_end  [STREAMS];
    logic             n_end  [STREAMS];
    logic [31:0]      r_last [STREAMS];
    logic [31:0]      n_last [STREAMS];

    logic             in_take;
    logic             out_free;
    logic [SEL_W-1:0] s;
    t_room            room;
    logic             ram_wr_en;
    logic             ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ADDR_W-1:0] ram_rd_addr;
    t_desc            ram_wr_data;
    t_desc            ram_rd_data;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign s        = SEL_W'(r_item.stream_sel % STREAMS);

    crba_room_unit u_room (
        .i_write_ptr  (r_wp[s]),
        .i_reader_ptr (r_rp[s]),
        .i_length     (r_item.chunk_length),
        .o_room       (room)
    );

    crba_ram #(
        .WIDTH (DESC_W),
        .DEPTH (SLOTS)
    ) u_desc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign ram_wr_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(DESCRIPTORS) + ADDR_W'(r_tail[s]));
    assign ram_rd_addr = ADDR_W'(ADDR_W'(s) * ADDR_W'(DESCRIPTORS) + ADDR_W'(r_head[s]));
    assign ram_wr_data = '{offset: r_wp[s], length: r_item.chunk_length,
                           stamp: r_item.chunk_stamp, position: r_item.source_position};

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_tail    = r_tail;
        n_end     = r_end;
        n_last    = r_last;
        ram_wr_en = 1'b0;
        ram_rd_en = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC, S_RETRY: begin
                n_res = '0;
                n_res.play_position = r_last[s];
                n_state = S_FIN;
                unique case (r_item.func)
                    FUNC_RESERVE: begin
                        priority if (r_item.chunk_length == '0) begin
                            n_res.status = STATUS_OK;
                        end else if (r_cnt[s] >= CNT_W'(DESCRIPTORS - 1)) begin
                            if (r_rp[s] == ARENA_END) begin
                                n_rp[s] = '0;
                            end
                            n_res.status = STATUS_NO_SPACE;
                        end else if (room.fits) begin
                            ram_wr_en         = 1'b1;
                            n_res.status      = STATUS_OK;
                            n_res.data_offset = OFF_W'(r_wp[s]);
                            n_wp[s]   = PTR_W'(CMP_W'(r_wp[s]) + CMP_W'(r_item.chunk_length));
                            n_tail[s] = (r_tail[s] == IDX_W'(DESCRIPTORS - 1)) ? '0
                                                                            : r_tail[s] + 1'b1;
                            n_cnt[s]  = r_cnt[s] + 1'b1;
                        end else if (!room.limit_is_end || r_state == S_RETRY) begin
                            n_res.status = STATUS_NO_SPACE;
                        end else begin
                            // wrap once and try again at offset 0
                            n_wp[s] = '0;
                            if (r_rp[s] == ARENA_END) begin
                                n_rp[s] = '0;
                            end
                            n_state = S_RETRY;
                        end
                    end
                    FUNC_POP: begin
                        if (r_cnt[s] != '0) begin
                            ram_rd_en = 1'b1;
                            n_head[s] = (r_head[s] == IDX_W'(DESCRIPTORS - 1)) ? '0
                                                                            : r_head[s] + 1'b1;
                            n_cnt[s]  = r_cnt[s] - 1'b1;
                            n_state   = S_POP;
                        end else begin
                            n_res.status = r_end[s] ? STATUS_EOS : STATUS_EMPTY;
                        end
                    end
                    FUNC_FLUSH, FUNC_REOPEN: begin
                        n_wp[s]   = '0;
                        n_rp[s]   = ARENA_END;
                        n_cnt[s]  = '0;
                        n_head[s] = '0;
                        n_tail[s] = '0;
                        if (r_item.func == FUNC_REOPEN) begin
                            n_end[s] = 1'b0;
                        end
                    end
                    FUNC_MARK: begin
                        n_end[s] = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_POP: begin
                n_last[s] = ram_rd_data.position;
                n_rp[s]   = ram_rd_data.offset;
                n_res.status          = STATUS_OK;
                n_res.data_offset     = OFF_W'(ram_rd_data.offset);
                n_res.popped_length   = ram_rd_data.length;
                n_res.popped_stamp    = ram_rd_data.stamp;
                n_res.popped_position = ram_rd_data.position;
                n_res.play_position   = ram_rd_data.position;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < STREAMS; k++) begin
                r_wp[k]   <= '0;
                r_rp[k]   <= ARENA_END;
                r_cnt[k]  <= '0;
                r_head[k] <= '0;
                r_tail[k] <= '0;
                r_end[k]  <= 1'b0;
                r_last[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_end   <= n_end;
            r_last  <= n_last;
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in_word;
        end
        r_res <= n_res;
        if (r_state == S_FIN && out_free) begin
            r_out_word <= r_res;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> rtl/crba_checker.sv
// Port-level checker for the ring buffer allocator, bound to the top level.
`include "contiguous_ring_buffer_allocator_unit_macros.svh"

module crba_checker import crba_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    `CRBA_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "reset must leave no result word and an open input")

    `CRBA_ASSERT(a_busy_after_take, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall, "an accepted word must hold the input stalled")

    `CRBA_ASSERT(a_out_held, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> o_out_valid, "a stalled result word must stay valid")

    `CRBA_ASSERT(a_fail_zeroed, i_clk, i_rst_n, (o_out_valid && o_out_word.status != STATUS_OK) |-> (o_out_word.data_offset == '0 && o_out_word.popped_length == '0), "a failed operation must report zero offset and length")

endmodule

bind contiguous_ring_buffer_allocator_unit crba_checker u_crba_checker (.*);

>>> tb/contiguous_ring_buffer_allocator_unit_tb.sv
// Self-checking testbench for the contiguous ring buffer allocator unit.
module contiguous_ring_buffer_allocator_unit_tb import crba_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_OPS   = 620;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_word  in_word = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_word o_out_word;

    int tx_idle_pct = 13;
    int rx_idle_pct = 64;
    int mismatch_count = 0;
    int cycle_count = 0;

    t_in_word  op_backlog[$];
    t_out_word predicted_words[$];

    // Shadow of the per-stream allocator state.
    logic [PTR_W-1:0] wr_ptr   [STREAMS];
    logic [PTR_W-1:0] rd_ptr   [STREAMS];
    logic [CNT_W-1:0] queued   [STREAMS];
    logic [IDX_W-1:0] head_idx [STREAMS];
    logic [IDX_W-1:0] tail_idx [STREAMS];
    logic             eos_flag [STREAMS];
    logic [31:0]      played   [STREAMS];
    t_desc            desc_mem [SLOTS];

    contiguous_ring_buffer_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (o_out_word)
    );

    always #1 i_clk = ~i_clk;

    function automatic void rewind_stream(int s);
        wr_ptr[s]   = '0;
        rd_ptr[s]   = ARENA_END;
        queued[s]   = '0;
        head_idx[s] = '0;
        tail_idx[s] = '0;
    endfunction

    function automatic t_out_word predict_allocation(t_in_word w);
        t_out_word r;
        t_desc     d;
        int        s;
        int        lim;
        int        tries;
        logic      settled;
        r = '0;
        s = int'(w.stream_sel) % STREAMS;
        case (w.func)
            FUNC_RESERVE: begin
                if (w.chunk_length != '0) begin
                    r.status = STATUS_NO_SPACE;
                    if (queued[s] >= DESCRIPTORS - 1) begin
                        if (rd_ptr[s] == ARENA_END) rd_ptr[s] = '0;
                    end else begin
                        settled = 1'b0;
                        // Second attempt only after wrapping to the arena start.
                        for (tries = 0; tries < 2; tries++) begin
                            if (!settled) begin
                                lim = (wr_ptr[s] <= rd_ptr[s]) ? int'(rd_ptr[s]) : ARENA_BYTES;
                                if (lim - int'(wr_ptr[s]) >= int'(w.chunk_length)) begin
                                    d.offset   = wr_ptr[s];
                                    d.length   = w.chunk_length;
                                    d.stamp    = w.chunk_stamp;
                                    d.position = w.source_position;
                                    desc_mem[s * DESCRIPTORS + int'(tail_idx[s])] = d;
                                    r.status      = STATUS_OK;
                                    r.data_offset = OFF_W'(wr_ptr[s]);
                                    wr_ptr[s]     = wr_ptr[s] + PTR_W'(w.chunk_length);
                                    tail_idx[s]   = IDX_W'((int'(tail_idx[s]) + 1) % DESCRIPTORS);
                                    queued[s]     = queued[s] + 1'b1;
                                    settled = 1'b1;
                                end else if (lim != ARENA_BYTES) begin
                                    settled = 1'b1;
                                end else begin
                                    wr_ptr[s] = '0;
                                    if (rd_ptr[s] == ARENA_END) rd_ptr[s] = '0;
                                end
                            end
                        end
                    end
                end
            end
            FUNC_POP: begin
                if (queued[s] != '0) begin
                    d = desc_mem[s * DESCRIPTORS + int'(head_idx[s])];
                    played[s]         = d.position;
                    rd_ptr[s]         = d.offset;
                    r.data_offset     = OFF_W'(d.offset);
                    r.popped_length   = d.length;
                    r.popped_stamp    = d.stamp;
                    r.popped_position = d.position;
                    head_idx[s] = IDX_W'((int'(head_idx[s]) + 1) % DESCRIPTORS);
                    queued[s]   = queued[s] - 1'b1;
                end else begin
                    r.status = eos_flag[s] ? STATUS_EOS : STATUS_EMPTY;
                end
            end
            FUNC_FLUSH: rewind_stream(s);
            FUNC_MARK: eos_flag[s] = 1'b1;
            FUNC_REOPEN: begin
                rewind_stream(s);
                eos_flag[s] = 1'b0;
            end
            default: ;
        endcase
        r.play_position = played[s];
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Driver: predict each accepted word, then load the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) predicted_words.push_back(predict_allocation(in_word));
            if (op_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                in_valid <= 1'b1;
                in_word  <= op_backlog.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Monitor: compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (predicted_words.size() == 0) begin
                $error("result word with no prediction pending: 0x%0h", o_out_word);
                mismatch_count++;
            end else begin
                want = predicted_words.pop_front();
                check_field("status", want.status, o_out_word.status);
                check_field("data_offset", want.data_offset, o_out_word.data_offset);
                check_field("popped_length", want.popped_length, o_out_word.popped_length);
                check_field("popped_stamp", want.popped_stamp, o_out_word.popped_stamp);
                check_field("popped_position", want.popped_position,
                            o_out_word.popped_position);
                check_field("play_position", want.play_position, o_out_word.play_position);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic queue_op(logic [2:0] f, int s, int len, logic [63:0] stamp,
                            logic [31:0] pos);
        t_in_word w;
        w.func            = f;
        w.stream_sel      = s[0];
        w.chunk_length    = LEN_W'(len);
        w.chunk_stamp     = stamp;
        w.source_position = pos;
        op_backlog.push_back(w);
    endtask

    task automatic queue_rand(logic [2:0] f, int s, int len);
        queue_op(f, s, len, {$urandom(), $urandom()}, $urandom());
    endtask

    function automatic int random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35) return $urandom_range(4095, 1);
        if (pick < 70) return $urandom_range(131071, 4096);
        if (pick < 85) return $urandom_range(ARENA_BYTES, 131072);
        if (pick < 95) return ARENA_BYTES - $urandom_range(4095);
        return $urandom_range(20'hFFFFF);
    endfunction

    // Fill one stream's descriptor FIFO to the brim, hit the full case, then drain part.
    task automatic queue_fill(int s);
        int k;
        queue_rand(FUNC_REOPEN, s, 0);
        for (k = 0; k < DESCRIPTORS + 2; k++) queue_rand(FUNC_RESERVE, s, $urandom_range(1024, 1));
        for (k = 0; k < 30; k++) begin
            if ($urandom_range(3) == 0) queue_rand(FUNC_RESERVE, s, random_length());
            else queue_rand(FUNC_POP, s, $urandom_range(20'hFFFFF));
        end
    endtask

    task automatic queue_phase(int target, int fill_s);
        int s;
        int n;
        int k;
        int pick;
        int sel;
        if (fill_s >= 0) queue_fill(fill_s);
        while (op_backlog.size() < target) begin
            s = $urandom_range(STREAMS - 1);
            n = $urandom_range(60, 10);
            for (k = 0; k < n; k++) begin
                sel  = ($urandom_range(99) < 85) ? s : $urandom_range(1);
                pick = $urandom_range(99);
                if (pick < 50) queue_rand(FUNC_RESERVE, sel, random_length());
                else if (pick < 85) queue_rand(FUNC_POP, sel, $urandom_range(20'hFFFFF));
                else if (pick < 89) queue_rand(FUNC_FLUSH, sel, $urandom_range(20'hFFFFF));
                else if (pick < 92) queue_rand(FUNC_REOPEN, sel, $urandom_range(20'hFFFFF));
                else if (pick < 96) queue_rand(FUNC_MARK, sel, $urandom_range(20'hFFFFF));
                else if (pick < 98) queue_rand(FUNC_RESERVE, sel, 0);
                else queue_rand(3'($urandom_range(7, 5)), sel, $urandom_range(20'hFFFFF));
            end
        end
    endtask

    task automatic wait_for_drain();
        do @(posedge i_clk);
        while (op_backlog.size() != 0 || in_valid || predicted_words.size() != 0);
    endtask

    initial begin : stimulus
        int s;
        for (s = 0; s < STREAMS; s++) begin
            rewind_stream(s);
            eos_flag[s] = 1'b0;
            played[s]   = '0;
        end

        // Empty, end of stream, zero and full-arena lengths, wraps that fail and succeed.
        queue_rand(FUNC_POP, 0, 0);
        queue_rand(FUNC_MARK, 0, 0);
        queue_rand(FUNC_POP, 0, 0);
        queue_rand(FUNC_RESERVE, 0, 0);
        queue_op(FUNC_RESERVE, 0, ARENA_BYTES, '1, '1);
        queue_rand(FUNC_RESERVE, 0, 1);
        queue_rand(FUNC_POP, 0, 0);
        queue_rand(FUNC_POP, 0, 0);
        queue_rand(FUNC_REOPEN, 0, 0);
        queue_rand(FUNC_POP, 0, 0);
        queue_op(FUNC_RESERVE, 1, 20'hFFFFF, '0, '0);
        queue_rand(FUNC_RESERVE, 1, 100);
        queue_rand(FUNC_FLUSH, 1, 0);
        queue_rand(FUNC_RESERVE, 1, 300000);
        queue_rand(FUNC_RESERVE, 1, 300000);
        queue_rand(FUNC_FLUSH, 1, 0);
        queue_rand(FUNC_RESERVE, 1, 300000);
        queue_rand(FUNC_POP, 1, 0);
        queue_rand(FUNC_RESERVE, 1, 200000);
        queue_rand(FUNC_RESERVE, 1, 100000);
        queue_rand(FUNC_POP, 1, 0);
        queue_rand(FUNC_RESERVE, 1, 100000);
        queue_rand(3'd5, 0, 20'hFFFFF);
        queue_rand(3'd6, 1, 0);
        queue_rand(3'd7, 1, 20'hFFFFF);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_phase(PHASE_OPS + 25, 0);
        wait_for_drain();

        // Hold the sender until everything is back, then swap the idle rates.
        tx_idle_pct <= 64;
        rx_idle_pct <= 13;
        queue_phase(PHASE_OPS, -1);
        wait_for_drain();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        queue_phase(PHASE_OPS, 1);
        wait_for_drain();

        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/crba_pkg.sv
rtl/crba_ram.sv
rtl/crba_room_unit.sv
rtl/contiguous_ring_buffer_allocator_unit.sv
rtl/crba_checker.sv
tb/contiguous_ring_buffer_allocator_unit_tb.sv
